// ===== sv/emaf_pkg.sv =====
// Shared types and constants of the multichannel ADC smoothing filter.
package emaf_pkg;

    // Sample and history formats.
    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 4;
    localparam int HIST_W      = SAMPLE_BITS + FRAC_BITS;
    localparam int WEIGHT_W    = 17;
    localparam int CHAN_W      = 2;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
    localparam logic [HIST_W-1:0]      HIST_MAX   = {HIST_W{1'b1}};

    // Filter arithmetic widths.
    localparam int KEEP_PROD_W  = WEIGHT_W + HIST_W;
    localparam int KEEP_TERM_W  = KEEP_PROD_W - FRAC_BITS;
    localparam int ALPHA_PROD_W = WEIGHT_W + SAMPLE_BITS;
    localparam int TMP_W        = KEEP_TERM_W + 2;
    localparam int Q16_SHIFT    = 16;
    localparam int HIST_SHIFT   = Q16_SHIFT - FRAC_BITS;

    localparam logic [KEEP_PROD_W-1:0] KEEP_ROUND = KEEP_PROD_W'(1 << (FRAC_BITS - 1));
    localparam logic [TMP_W-1:0]       HIST_ROUND = TMP_W'(1 << (HIST_SHIFT - 1));

    // Millivolt scaling against the reference voltage.
    localparam int MV_W      = 12;
    localparam int MV_PROD_W = SAMPLE_BITS + MV_W;
    localparam logic [MV_W-1:0] REF_MV = MV_W'(3300);

    // Configuration register map: two weights per channel.
    localparam int REG_COUNT = 8;
    localparam int CFG_IDX_W = 3;
    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_KEEP  = 1'b1;

    // Weights after reset.
    localparam int                  FAST_CHANNEL = 2;
    localparam logic [WEIGHT_W-1:0] SLOW_ALPHA   = WEIGHT_W'(655);
    localparam logic [WEIGHT_W-1:0] SLOW_KEEP    = WEIGHT_W'(64880);
    localparam logic [WEIGHT_W-1:0] FAST_ALPHA   = WEIGHT_W'(32768);
    localparam logic [WEIGHT_W-1:0] FAST_KEEP    = WEIGHT_W'(32768);

    typedef enum logic [0:0] {
        OP_FILTER = 1'b0,
        OP_SEED   = 1'b1
    } op_t;

    typedef struct packed {
        op_t                    operation;
        logic [CHAN_W-1:0]      channel;
        logic [SAMPLE_BITS-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0]      channel_out;
        logic [SAMPLE_BITS-1:0] smoothed;
        logic [MV_W-1:0]        millivolts;
    } out_word_t;

endpackage

// ===== sv/emaf_stream_if.sv =====
// Valid/ready stream channel carrying one payload word per handshake.
interface emaf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/multichannel_ema_adc_filter.sv =====
// Four-channel exponential moving average filter for 12-bit ADC words, one word per
// clock unless the output is held off: a word is registered, the filter step and
// history update run between that register and the value register, and the millivolt
// scaling runs before the output register, so a word can follow in every cycle. A
// held-off output stalls the three stages, and the input drops ready once all of them
// are full. The history of the next word's channel is already updated when it is used,
// so consecutive words on one channel are handled correctly. A word with a channel at
// or above CHANNELS is accepted and dropped. The user must write weights through the
// cfg port only while no word is in flight; the block itself does not enforce this.
module multichannel_ema_adc_filter #(
    parameter int CHANNELS = 4
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    emaf_stream_if.sink                             in,
    emaf_stream_if.source                           out,
    input  logic                                    cfg_we,
    input  logic [emaf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [emaf_pkg::WEIGHT_W-1:0]           cfg_data
);
    import emaf_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Channel state and weights.
    logic [WEIGHT_W-1:0] alpha_reg   [CHANNELS];
    logic [WEIGHT_W-1:0] keep_reg    [CHANNELS];
    logic [HIST_W-1:0]   history_reg [CHANNELS];
    logic [CHANNELS-1:0] seeded_reg;

    // Input stage.
    logic                   a_valid_reg;
    op_t                    a_op_reg;
    logic [CHAN_W-1:0]      a_ch_reg;
    logic [CH_IDX_W-1:0]    a_idx_reg;
    logic [SAMPLE_BITS-1:0] a_sample_reg;

    // Value stage.
    logic                   b_valid_reg;
    logic [CHAN_W-1:0]      b_ch_reg;
    logic [SAMPLE_BITS-1:0] b_value_reg;

    // Output stage.
    logic                   out_valid_reg;
    out_word_t              out_word_reg;

    logic out_en, b_en, a_en, ch_ok;
    logic [CH_IDX_W-1:0] cfg_idx;

    assign out_en   = !out_valid_reg || out.ready;
    assign b_en     = !b_valid_reg || out_en;
    assign a_en     = !a_valid_reg || b_en;
    assign in.ready = a_en;
    assign ch_ok    = (32'(in.payload.channel) < CHANNELS);
    assign cfg_idx  = CH_IDX_W'(cfg_index[CFG_IDX_W-1:1]);

    assign out.valid   = out_valid_reg;
    assign out.payload = out_word_reg;

    // Filter step for the word in the input stage.
    logic [HIST_W-1:0]       seed_hist, hist_cur, hist_new;
    logic [KEEP_PROD_W-1:0]  keep_prod;
    logic [KEEP_TERM_W-1:0]  keep_term;
    logic [ALPHA_PROD_W-1:0] alpha_prod;
    logic [TMP_W-1:0]        tmp, nh_full, val_full;
    logic [SAMPLE_BITS-1:0]  value_new;
    logic                    a_fire;

    assign a_fire = a_valid_reg && b_en;

    always_comb
    begin
        seed_hist  = {a_sample_reg, {FRAC_BITS{1'b0}}};
        // An unseeded channel is seeded from the sample before filtering.
        hist_cur   = seeded_reg[a_idx_reg] ? history_reg[a_idx_reg] : seed_hist;
        keep_prod  = KEEP_PROD_W'(keep_reg[a_idx_reg]) * KEEP_PROD_W'(hist_cur);
        keep_term  = KEEP_TERM_W'((keep_prod + KEEP_ROUND) >> FRAC_BITS);
        alpha_prod = ALPHA_PROD_W'(alpha_reg[a_idx_reg]) * ALPHA_PROD_W'(a_sample_reg);
        tmp        = TMP_W'(alpha_prod) + TMP_W'(keep_term);
        nh_full    = (tmp + HIST_ROUND) >> HIST_SHIFT;
        val_full   = tmp >> Q16_SHIFT;
        unique case (a_op_reg)
            OP_SEED:
            begin
                hist_new  = seed_hist;
                value_new = a_sample_reg;
            end
            default:
            begin
                hist_new  = (nh_full > TMP_W'(HIST_MAX)) ? HIST_MAX : nh_full[HIST_W-1:0];
                value_new = (val_full > TMP_W'(FULL_SCALE)) ? FULL_SCALE
                                                            : val_full[SAMPLE_BITS-1:0];
            end
        endcase
    end

    // Millivolts: floor(v * 3300 / full scale), with full scale one below a power of two.
    logic [MV_PROD_W-1:0]   mv_prod;
    logic [MV_W-1:0]        mv_q0;
    logic [SAMPLE_BITS:0]   mv_rem;
    logic [MV_W-1:0]        mv_next;

    always_comb
    begin
        mv_prod = MV_PROD_W'(b_value_reg) * MV_PROD_W'(REF_MV);
        mv_q0   = MV_W'(mv_prod >> SAMPLE_BITS);
        mv_rem  = {1'b0, mv_prod[SAMPLE_BITS-1:0]} + (SAMPLE_BITS+1)'(mv_q0);
        mv_next = mv_q0 + MV_W'(mv_rem >= (SAMPLE_BITS+1)'(FULL_SCALE));
    end

    // Control and channel state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            seeded_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                alpha_reg[i]   <= (i == FAST_CHANNEL) ? FAST_ALPHA : SLOW_ALPHA;
                keep_reg[i]    <= (i == FAST_CHANNEL) ? FAST_KEEP : SLOW_KEEP;
                history_reg[i] <= '0;
            end
        end
        else
        begin
            if (a_en)
                a_valid_reg <= in.valid && ch_ok;
            if (b_en)
                b_valid_reg <= a_valid_reg;
            if (out_en)
                out_valid_reg <= b_valid_reg;
            if (a_fire)
            begin
                history_reg[a_idx_reg] <= hist_new;
                seeded_reg[a_idx_reg]  <= 1'b1;
            end
            if (cfg_we && (32'(cfg_index[CFG_IDX_W-1:1]) < CHANNELS))
            begin
                unique case (cfg_index[0])
                    REG_ALPHA: alpha_reg[cfg_idx] <= cfg_data;
                    default:   keep_reg[cfg_idx]  <= cfg_data;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_op_reg     <= in.payload.operation;
            a_ch_reg     <= in.payload.channel;
            a_idx_reg    <= CH_IDX_W'(in.payload.channel);
            a_sample_reg <= in.payload.sample;
        end
        if (b_en)
        begin
            b_ch_reg    <= a_ch_reg;
            b_value_reg <= value_new;
        end
        if (out_en)
        begin
            out_word_reg.channel_out <= b_ch_reg;
            out_word_reg.smoothed    <= b_value_reg;
            out_word_reg.millivolts  <= mv_next;
        end
    end

    // A channel once seeded stays seeded until reset.
    a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((seeded_reg & $past(seeded_reg)) == $past(seeded_reg)))
        else $error("seeded flag cleared");

    // A seed word leaves the sample with four fraction bits in the history.
    a_seed_history: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && a_op_reg == OP_SEED) |=>
        (history_reg[$past(a_idx_reg)] == {$past(a_sample_reg), {FRAC_BITS{1'b0}}}))
        else $error("seed did not load history");

    // Every filtered word leaves its channel seeded.
    a_fire_seeds: assert property (@(posedge clk) disable iff (!rst_n)
        a_fire |=> seeded_reg[$past(a_idx_reg)])
        else $error("channel not seeded after a word");

    // The scaled result never exceeds the reference voltage.
    a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.millivolts <= REF_MV))
        else $error("millivolts out of range");

endmodule
